FILE: src/clc_pkg.sv
// ============================================================================
// clc_pkg: shared types and constants of the circular lag correlator
// Item layouts, configuration register codes, reset values and the command
// and status groups that join the controller to the datapath.
// ============================================================================
`timescale 1ns / 1ps

package clc_pkg;

    // Fixed field widths of the items.
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LAGS    = 16;
    localparam int DEF_MAX_DIM = 16;
    localparam int LAG_W       = 4;
    localparam int DIST_W      = 20;
    localparam int CORR_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIM_W       = 5;
    localparam int AXIS_W      = 2;
    localparam int SPACING_W   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Saturation limits of the Q16.16 result.
    localparam logic [CORR_W-1:0] CORR_MAX = 32'h7FFF_FFFF;
    localparam logic [CORR_W-1:0] CORR_MIN = 32'h8000_0000;

    // Shift axis codes.
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Configuration register reset values.
    localparam logic [DIM_W-1:0]     RST_SIZE        = 5'd16;
    localparam logic [AXIS_W-1:0]    RST_SHIFT_AXIS  = AXIS_X;
    localparam logic [DIM_W-1:0]     RST_LAG_COUNT   = 5'd8;
    localparam logic [SPACING_W-1:0] RST_LAG_SPACING = 16'd256;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X      = 3'd0,
        REG_SIZE_Y      = 3'd1,
        REG_SIZE_Z      = 3'd2,
        REG_SHIFT_AXIS  = 3'd3,
        REG_LAG_COUNT   = 3'd4,
        REG_LAG_SPACING = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [DIM_W-1:0]     size_x;
        logic [DIM_W-1:0]     size_y;
        logic [DIM_W-1:0]     size_z;
        logic [AXIS_W-1:0]    shift_axis;
        logic [DIM_W-1:0]     lag_count;
        logic [SPACING_W-1:0] lag_spacing;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_a;
        logic signed [SAMPLE_BITS-1:0] sample_b;
    } in_item_t;

    typedef struct packed {
        logic [LAG_W-1:0]         lag_index;
        logic [DIST_W-1:0]        distance;
        logic signed [CORR_W-1:0] correlation;
        logic                     zero_mean;
        logic                     last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic frame_start;
        logic lag_start;
        logic sweep;
        logic scale;
        logic div_init;
        logic div_step;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_full;
        logic sweep_last;
        logic pipe_busy;
        logic div_last;
        logic lag_last;
        logic out_free;
    } stat_t;

endpackage

FILE: src/circular_lag_correlation_3d.sv
// After an item is accepted, the sequencer passes the size-settling states and the
// frame check before it takes the next item. The final item of a frame then runs, per
// lag, a sweep over every cell through the single read port of each sample store, the
// scaling and a serial divider; no new item is taken until the last result is out.
// Reset (synchronous, active low) restores the register defaults and empties the frame;
// the sample stores are not cleared and hold data only once written.
// ============================================================================
// circular_lag_correlation_3d: mean-normalized circular lag correlator
// Loads paired samples of two 3D grids, then reports one normalized circular
// cross-correlation result per lag along the chosen axis.
// ============================================================================
`timescale 1ns / 1ps

module circular_lag_correlation_3d #(
    parameter int MAX_DIM = clc_pkg::DEF_MAX_DIM
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  clc_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output clc_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [clc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import clc_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.size_x      <= RST_SIZE;
            cfg_reg.size_y      <= RST_SIZE;
            cfg_reg.size_z      <= RST_SIZE;
            cfg_reg.shift_axis  <= RST_SHIFT_AXIS;
            cfg_reg.lag_count   <= RST_LAG_COUNT;
            cfg_reg.lag_spacing <= RST_LAG_SPACING;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_SIZE_X:      cfg_reg.size_x      <= cfg_data[DIM_W-1:0];
                REG_SIZE_Y:      cfg_reg.size_y      <= cfg_data[DIM_W-1:0];
                REG_SIZE_Z:      cfg_reg.size_z      <= cfg_data[DIM_W-1:0];
                REG_SHIFT_AXIS:  cfg_reg.shift_axis  <= cfg_data[AXIS_W-1:0];
                REG_LAG_COUNT:   cfg_reg.lag_count   <= cfg_data[DIM_W-1:0];
                REG_LAG_SPACING: cfg_reg.lag_spacing <= cfg_data[SPACING_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    clc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Storage and arithmetic.
    clc_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule

FILE: src/clc_ram.sv
// ============================================================================
// clc_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ============================================================================
`timescale 1ns / 1ps

module clc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/clc_ctrl.sv
// ============================================================================
// clc_ctrl: sequencer of the circular lag correlator
// Steps each item through loading, and on a full frame through the lag
// sweeps, the scaling, the serial division and the result hand-off.
// ============================================================================
`timescale 1ns / 1ps

module clc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  clc_pkg::stat_t stat,
    output clc_pkg::cmd_t  cmd
);

    import clc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_SIZE1  = 11'b000_0000_0010,
        S_SIZE2  = 11'b000_0000_0100,
        S_CHECK  = 11'b000_0000_1000,
        S_LSTART = 11'b000_0001_0000,
        S_SWEEP  = 11'b000_0010_0000,
        S_DRAIN  = 11'b000_0100_0000,
        S_SCALE  = 11'b000_1000_0000,
        S_DIVSET = 11'b001_0000_0000,
        S_DIVIDE = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SIZE1;
                end
            end
            // The grid size products settle in S_SIZE1 and S_SIZE2.
            S_SIZE1: state_next = S_SIZE2;
            S_SIZE2: state_next = S_CHECK;
            S_CHECK: begin
                if (stat.frame_full) begin
                    cmd.frame_start = 1'b1;
                    state_next      = S_LSTART;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_LSTART: begin
                cmd.lag_start = 1'b1;
                state_next    = S_SWEEP;
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = S_DIVSET;
            end
            S_DIVSET: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIVIDE;
            end
            S_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = stat.lag_last ? S_IDLE : S_LSTART;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

FILE: src/clc_datapath.sv
// ============================================================================
// clc_datapath: storage and arithmetic of the circular lag correlator
// Sample stores, running sums, the address walk with circular wrap, the
// multiply-accumulate pipeline, the serial divider and the result register.
// ============================================================================
`timescale 1ns / 1ps

module clc_datapath #(
    parameter int MAX_DIM = clc_pkg::DEF_MAX_DIM
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  clc_pkg::cfg_t       cfg,
    input  clc_pkg::cmd_t       cmd,
    output clc_pkg::stat_t      stat,
    input  clc_pkg::in_item_t   s_data,
    output clc_pkg::out_item_t  m_data,
    output logic                m_valid,
    input  logic                m_ready
);

    import clc_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int DW     = $clog2(MAX_DIM);
    localparam int EW     = $clog2(MAX_DIM + 1);
    localparam int PW     = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int XW     = AW + 1;
    localparam int LCW    = $clog2(MAX_LAGS + 1);
    localparam int SUM_W  = SAMPLE_BITS + AW + 1;
    localparam int DEN_W  = 2 * SUM_W;
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + AW;
    localparam int NUM_W  = CW + ACC_W;
    localparam int REM_W  = DEN_W + 1;
    localparam int Q_W    = CORR_W;
    localparam int DCW    = $clog2(Q_W);
    localparam int SFW    = XW + LAG_W;
    localparam int DFW    = LAG_W + SPACING_W;

    function automatic logic [EW-1:0] clamp_dim(logic [DIM_W-1:0] v);
        int t;
        t = (v == '0) ? 1 : ((int'(v) > MAX_DIM) ? MAX_DIM : int'(v));
        return EW'(t);
    endfunction

    // Effective geometry.
    logic [EW-1:0]     nx, ny, nz, ext;
    logic [AXIS_W-1:0] axis;
    logic [LCW-1:0]    lags;
    int                lags_i;

    assign nx   = clamp_dim(cfg.size_x);
    assign ny   = clamp_dim(cfg.size_y);
    assign nz   = clamp_dim(cfg.size_z);
    assign axis = (cfg.shift_axis > AXIS_Z) ? AXIS_Z : cfg.shift_axis;

    always_comb begin
        case (axis)
            AXIS_X:  ext = nx;
            AXIS_Y:  ext = ny;
            default: ext = nz;
        endcase
        lags_i = (cfg.lag_count == '0) ? 1 : int'(cfg.lag_count);
        if (lags_i > int'(ext)) begin
            lags_i = int'(ext);
        end
        if (lags_i > MAX_LAGS) begin
            lags_i = MAX_LAGS;
        end
        lags = LCW'(lags_i);
    end

    // Grid size products, one multiply per register.
    logic [PW-1:0] nxy_reg, nyz_reg;
    logic [CW-1:0] n_reg;

    always_ff @(posedge aclk) begin
        nxy_reg <= PW'(int'(nx) * int'(ny));
        nyz_reg <= PW'(int'(ny) * int'(nz));
        n_reg   <= CW'(int'(nxy_reg) * int'(nz));
    end

    // Index distance of one lag step and of a full turn along the axis.
    logic [XW-1:0] stride, wrap;

    always_comb begin
        case (axis)
            AXIS_X: begin
                stride = XW'(nyz_reg);
                wrap   = XW'(n_reg);
            end
            AXIS_Y: begin
                stride = XW'(nz);
                wrap   = XW'(nyz_reg);
            end
            default: begin
                stride = XW'(1);
                wrap   = XW'(nz);
            end
        endcase
    end

    // Frame loading: counter and running sums.
    logic [CW-1:0]           load_count_reg;
    logic signed [SUM_W-1:0] sum_a_reg, sum_b_reg;
    logic                    frame_clear;
    logic                    store_we;

    assign frame_clear = cmd.emit && stat.lag_last;
    assign store_we    = cmd.load && (load_count_reg < CW'(DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
        end else if (cmd.load) begin
            load_count_reg <= load_count_reg + CW'(1);
            sum_a_reg      <= sum_a_reg + SUM_W'(s_data.sample_a);
            sum_b_reg      <= sum_b_reg + SUM_W'(s_data.sample_b);
        end else if (frame_clear) begin
            load_count_reg <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
        end
    end

    // Denominator and flags taken once per frame.
    logic [SUM_W-1:0] mag_a, mag_b;
    logic [DEN_W-1:0] den_reg;
    logic             zero_reg, sign_ab_reg;
    logic [LAG_W-1:0] lag_reg;

    assign mag_a = sum_a_reg[SUM_W-1] ? SUM_W'(-sum_a_reg) : SUM_W'(sum_a_reg);
    assign mag_b = sum_b_reg[SUM_W-1] ? SUM_W'(-sum_b_reg) : SUM_W'(sum_b_reg);

    always_ff @(posedge aclk) begin
        if (cmd.frame_start) begin
            den_reg     <= DEN_W'(mag_a) * DEN_W'(mag_b);
            zero_reg    <= (sum_a_reg == '0) || (sum_b_reg == '0);
            sign_ab_reg <= sum_a_reg[SUM_W-1] ^ sum_b_reg[SUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_reg <= '0;
        end else if (cmd.frame_start) begin
            lag_reg <= '0;
        end else if (cmd.emit) begin
            lag_reg <= lag_reg + LAG_W'(1);
        end
    end

    // Address walk over the grid.
    logic [DW-1:0]  cx_reg, cy_reg, cz_reg, coord;
    logic [AW-1:0]  k_reg, l_addr;
    logic [XW-1:0]  step_reg;
    logic [SFW-1:0] step_full;
    logic [AW+1:0]  l_sum;
    logic           rolled, x_last, y_last, z_last;

    assign step_full = SFW'(lag_reg) * SFW'(stride);
    assign x_last    = int'(cx_reg) == int'(nx) - 1;
    assign y_last    = int'(cy_reg) == int'(ny) - 1;
    assign z_last    = int'(cz_reg) == int'(nz) - 1;

    always_comb begin
        case (axis)
            AXIS_X:  coord = cx_reg;
            AXIS_Y:  coord = cy_reg;
            default: coord = cz_reg;
        endcase
    end

    // The partner cell wraps around when the shifted coordinate leaves the grid.
    assign rolled = (int'(coord) + int'(lag_reg)) >= int'(ext);
    assign l_sum  = (AW+2)'(k_reg) + (AW+2)'(step_reg)
                    - (rolled ? (AW+2)'(wrap) : (AW+2)'(0));
    assign l_addr = l_sum[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.lag_start) begin
            step_reg <= step_full[XW-1:0];
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
            k_reg    <= '0;
        end else if (cmd.sweep) begin
            k_reg <= k_reg + AW'(1);
            if (z_last) begin
                cz_reg <= '0;
                if (y_last) begin
                    cy_reg <= '0;
                    cx_reg <= x_last ? '0 : cx_reg + DW'(1);
                end else begin
                    cy_reg <= cy_reg + DW'(1);
                end
            end else begin
                cz_reg <= cz_reg + DW'(1);
            end
        end
    end

    // Sample stores.
    logic [SAMPLE_BITS-1:0] rd_a, rd_b;

    clc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store_a (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (load_count_reg[AW-1:0]),
        .wdata (s_data.sample_a),
        .raddr (k_reg),
        .rdata (rd_a)
    );

    clc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store_b (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (load_count_reg[AW-1:0]),
        .wdata (s_data.sample_b),
        .raddr (l_addr),
        .rdata (rd_b)
    );

    // Multiply-accumulate pipeline: read, multiply, accumulate.
    logic                     v1_reg, v2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.sweep;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            prod_reg <= $signed(rd_a) * $signed(rd_b);
        end
        if (cmd.lag_start) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Numerator scaling by the cell count.
    logic [ACC_W-1:0] mag_p;
    logic [NUM_W-1:0] num_reg;
    logic             neg_reg, numz_reg;

    assign mag_p = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_ff @(posedge aclk) begin
        if (cmd.scale) begin
            num_reg  <= NUM_W'(n_reg) * NUM_W'(mag_p);
            neg_reg  <= acc_reg[ACC_W-1] ^ sign_ab_reg;
            numz_reg <= (mag_p == '0);
        end
    end

    // Restoring division, one quotient bit per cycle.
    logic [REM_W-1:0] rem_reg, rem_shift;
    logic [Q_W-1:0]   q_reg, dsh_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic             sat_reg, rem_ge;

    assign rem_shift = {rem_reg[REM_W-2:0], dsh_reg[Q_W-1]};
    assign rem_ge    = rem_shift >= REM_W'(den_reg);

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            sat_reg     <= (DEN_W+FRAC_BITS)'(num_reg) >= {den_reg, {FRAC_BITS{1'b0}}};
            rem_reg     <= REM_W'(num_reg >> FRAC_BITS);
            dsh_reg     <= {num_reg[FRAC_BITS-1:0], {(Q_W-FRAC_BITS){1'b0}}};
            q_reg       <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_ge ? rem_shift - REM_W'(den_reg) : rem_shift;
            dsh_reg     <= {dsh_reg[Q_W-2:0], 1'b0};
            q_reg       <= {q_reg[Q_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end
    end

    // Signed, saturated Q16.16 result.
    logic [CORR_W-1:0] corr;

    always_comb begin
        if (zero_reg || numz_reg) begin
            corr = '0;
        end else if (sat_reg) begin
            corr = neg_reg ? CORR_MIN : CORR_MAX;
        end else if (neg_reg) begin
            corr = (q_reg > CORR_MIN) ? CORR_MIN : -q_reg;
        end else begin
            corr = q_reg[Q_W-1] ? CORR_MAX : q_reg;
        end
    end

    // Result register.
    logic [DFW-1:0] dist_full;
    out_item_t      out_reg;
    logic           m_valid_reg;

    assign dist_full = DFW'(lag_reg) * DFW'(cfg.lag_spacing);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.lag_index   <= lag_reg;
            out_reg.distance    <= DIST_W'(dist_full);
            out_reg.correlation <= corr;
            out_reg.zero_mean   <= zero_reg;
            out_reg.last        <= stat.lag_last;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    // Status to the controller.
    assign stat.frame_full = load_count_reg >= n_reg;
    assign stat.sweep_last = x_last && y_last && z_last;
    assign stat.pipe_busy  = v1_reg || v2_reg;
    assign stat.div_last   = div_cnt_reg == DCW'(Q_W - 1);
    assign stat.lag_last   = (LCW'(lag_reg) + LCW'(1)) == lags;
    assign stat.out_free   = !m_valid_reg || m_ready;

`ifndef SYNTHESIS
    // A result is only loaded into a free output register.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result loaded while output register is occupied");

    // Scaling only starts once the product pipeline has drained.
    a_scale_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scale |-> !v1_reg && !v2_reg)
        else $error("scaling started with products still in flight");

    // Every partner read stays inside the loaded frame.
    a_partner_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep |-> CW'(l_addr) < n_reg)
        else $error("partner address outside the grid");

    // The last result of a frame leaves the loader empty.
    a_frame_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && stat.lag_last |=> load_count_reg == '0 && sum_a_reg == '0)
        else $error("frame state not cleared after the last result");
`endif

endmodule

FILE: test/testbench.sv
// ============================================================================
// testbench: self-checking test of circular_lag_correlation_3d
// Loads small 3D grid pairs under many register settings, predicts every
// lag result of each frame in a local model and compares them field by
// field, while the sender and the receiver idle at random.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import clc_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int SETTLE_CYCLES = 50;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the registers and the frame state.
    logic [DIM_W-1:0]     sh_size_x     = RST_SIZE;
    logic [DIM_W-1:0]     sh_size_y     = RST_SIZE;
    logic [DIM_W-1:0]     sh_size_z     = RST_SIZE;
    logic [AXIS_W-1:0]    sh_axis       = RST_SHIFT_AXIS;
    logic [DIM_W-1:0]     sh_lag_count  = RST_LAG_COUNT;
    logic [SPACING_W-1:0] sh_lag_spacing = RST_LAG_SPACING;
    longint               grid_a [STORE_DEPTH];
    longint               grid_b [STORE_DEPTH];
    longint               run_sum_a     = 0;
    longint               run_sum_b     = 0;
    int                   pairs_loaded  = 0;

    out_item_t pending_lags [$];
    out_item_t got, want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int lag_results    = 0;
    int frames_closed  = 0;
    int pairs_sent     = 0;

    circular_lag_correlation_3d DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Effective extent: zero acts as one, anything above the maximum is clamped.
    function automatic int eff_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        return (v > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(v);
    endfunction

    function automatic int grid_cells();
        return eff_dim(sh_size_x) * eff_dim(sh_size_y) * eff_dim(sh_size_z);
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Q16.16 quotient, truncated toward zero and saturated.
    function automatic logic [CORR_W-1:0] q16_quotient(longint unsigned num,
                                                       longint unsigned den, bit neg);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        if (q >= 65536) return neg ? CORR_MIN : CORR_MAX;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        if (neg) begin
            if (q > 64'h8000_0000) return CORR_MIN;
            return CORR_W'(64'd0 - q);
        end
        return (q > 64'h7FFF_FFFF) ? CORR_MAX : CORR_W'(q);
    endfunction

    // Load one accepted pair; on the closing pair, queue every lag result.
    function automatic void load_pair(in_item_t d);
        int nx, ny, nz, n, ax, ext, lags, rx, ry, rz, k, l;
        longint acc;
        longint unsigned den, num;
        bit zero;
        out_item_t r;
        nx = eff_dim(sh_size_x);
        ny = eff_dim(sh_size_y);
        nz = eff_dim(sh_size_z);
        n = nx * ny * nz;
        ax = (sh_axis > AXIS_Z) ? int'(AXIS_Z) : int'(sh_axis);
        ext = (ax == AXIS_X) ? nx : ((ax == AXIS_Y) ? ny : nz);
        lags = (sh_lag_count == 0) ? 1 : int'(sh_lag_count);
        if (lags > ext) lags = ext;
        if (lags > MAX_LAGS) lags = MAX_LAGS;
        if (pairs_loaded < STORE_DEPTH) begin
            grid_a[pairs_loaded] = d.sample_a;
            grid_b[pairs_loaded] = d.sample_b;
        end
        run_sum_a += d.sample_a;
        run_sum_b += d.sample_b;
        pairs_loaded++;
        if (pairs_loaded < n) return;
        den = magnitude(run_sum_a) * magnitude(run_sum_b);
        zero = (run_sum_a == 0) || (run_sum_b == 0) || (den == 0);
        for (int lag = 0; lag < lags; lag++) begin
            acc = 0;
            for (int x = 0; x < nx; x++)
                for (int y = 0; y < ny; y++)
                    for (int z = 0; z < nz; z++) begin
                        rx = (ax == AXIS_X) ? ((x + lag < nx) ? x + lag : x + lag - nx) : x;
                        ry = (ax == AXIS_Y) ? ((y + lag < ny) ? y + lag : y + lag - ny) : y;
                        rz = (ax == AXIS_Z) ? ((z + lag < nz) ? z + lag : z + lag - nz) : z;
                        k = (x * ny + y) * nz + z;
                        l = (rx * ny + ry) * nz + rz;
                        acc += grid_a[k] * grid_b[l];
                    end
            num = longint'(n) * magnitude(acc);
            r.lag_index   = LAG_W'(lag);
            r.distance    = DIST_W'(lag * int'(sh_lag_spacing));
            r.correlation = '0;
            if (!zero && num != 0)
                r.correlation = q16_quotient(num, den,
                    (acc < 0) != ((run_sum_a < 0) != (run_sum_b < 0)));
            r.zero_mean = zero;
            r.last      = (lag + 1 == lags);
            pending_lags.push_back(r);
        end
        pairs_loaded = 0;
        run_sum_a = 0;
        run_sum_b = 0;
        frames_closed++;
    endfunction

    // Receiver: random stalls, and every accepted result checked in order.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            got = m_data;
            lag_results++;
            if (pending_lags.size() == 0) begin
                $error("unexpected result: lag_index %0d", got.lag_index);
                errors++;
            end else begin
                want = pending_lags.pop_front();
                if (got.lag_index !== want.lag_index) begin
                    $error("lag_index: expected %0d, got %0d", want.lag_index, got.lag_index);
                    errors++;
                end
                if (got.distance !== want.distance) begin
                    $error("distance: expected %0h, got %0h", want.distance, got.distance);
                    errors++;
                end
                if (got.correlation !== want.correlation) begin
                    $error("correlation: expected %0h, got %0h",
                           want.correlation, got.correlation);
                    errors++;
                end
                if (got.zero_mean !== want.zero_mean) begin
                    $error("zero_mean: expected %0b, got %0b", want.zero_mean, got.zero_mean);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, got.last);
                    errors++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Send one pair, then idle for a random gap; valid stays high when no gap.
    task automatic send_pair(logic signed [SAMPLE_BITS-1:0] a,
                             logic signed [SAMPLE_BITS-1:0] b);
        int gap;
        s_valid <= 1'b1;
        s_data  <= '{sample_a: a, sample_b: b};
        do @(posedge aclk); while (!s_ready);
        load_pair('{sample_a: a, sample_b: b});
        pairs_sent++;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid right after the last accepted item, then wait for all results.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_lags.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; unused upper data bits may carry junk from the caller.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SIZE_X:      sh_size_x = val[DIM_W-1:0];
            REG_SIZE_Y:      sh_size_y = val[DIM_W-1:0];
            REG_SIZE_Z:      sh_size_z = val[DIM_W-1:0];
            REG_SHIFT_AXIS:  sh_axis = val[AXIS_W-1:0];
            REG_LAG_COUNT:   sh_lag_count = val[DIM_W-1:0];
            REG_LAG_SPACING: sh_lag_spacing = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(int x, int y, int z, int axis, int lags, int spacing);
        wait_idle();
        write_reg(REG_SIZE_X, {11'($urandom), 5'(x)});
        write_reg(REG_SIZE_Y, {11'($urandom), 5'(y)});
        write_reg(REG_SIZE_Z, {11'($urandom), 5'(z)});
        write_reg(REG_SHIFT_AXIS, {14'($urandom), 2'(axis)});
        write_reg(REG_LAG_COUNT, {11'($urandom), 5'(lags)});
        write_reg(REG_LAG_SPACING, 16'(spacing));
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            1: return SAMPLE_BITS'($urandom_range(0, 16) - 8);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_frame();
        int n;
        n = grid_cells();
        for (int i = 0; i < n; i++) send_pair(pick_sample(), pick_sample());
    endtask

    // Extremes of the samples along a line, with the reset lag count and spacing.
    task automatic test_sample_extremes();
        set_geometry(8, 1, 1, AXIS_X, RST_LAG_COUNT, RST_LAG_SPACING);
        send_pair(16'sh7FFF, 16'sh8000);
        send_pair(16'sh8000, 16'sh7FFF);
        send_pair(16'sh0000, -16'sd1);
        send_pair(-16'sd1, 16'sh0001);
        send_pair(16'sh5555, 16'shAAAA);
        send_pair(16'shAAAA, 16'sh5555);
        send_pair(16'sh0001, 16'sh0000);
        send_pair(16'sh0100, 16'sh7FFF);
    endtask

    // Zero sum, degenerate sizes and selectors, saturation both ways.
    task automatic test_special_cases();
        set_geometry(2, 1, 1, AXIS_X, 2, 65535);
        send_pair(16'sd5, 16'sd3);
        send_pair(-16'sd5, 16'sd9);
        set_geometry(0, 0, 0, 3, 0, 0);
        send_pair(16'sd7, -16'sd2);
        set_geometry(1, 2, 0, 3, 31, 65535);
        send_pair(16'sh7FFF, 16'sh7FFF);
        send_pair(-16'sd32766, -16'sd32766);
        set_geometry(1, 2, 1, AXIS_Y, 2, 1);
        send_pair(16'sh7FFF, -16'sd32767);
        send_pair(-16'sd32766, 16'sd32766);
        set_geometry(1, 1, 31, AXIS_Z, 16, 4096);
        send_frame();
    endtask

    // Shrinking the grid mid-frame closes the frame on the next pair.
    task automatic test_shrink_mid_frame();
        set_geometry(4, 4, 1, AXIS_X, 4, 300);
        for (int i = 0; i < 10; i++) send_pair(pick_sample(), pick_sample());
        wait_idle();
        write_reg(REG_SIZE_X, 16'd2);
        write_reg(REG_SIZE_Y, 16'd2);
        send_pair(pick_sample(), pick_sample());
    endtask

    // Random geometries: the shift axis may span the full extent, the rest stay small.
    task automatic test_random_frames(int send_pct, int recv_pct, int quota);
        int start, ax, e0, e1, e2;
        wait_idle();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start = pairs_sent;
        while (pairs_sent - start < quota) begin
            ax = $urandom_range(0, 3);
            e0 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
            e1 = $urandom_range(0, 3);
            e2 = $urandom_range(0, 3);
            case (ax)
                0:       set_geometry(e0, e1, e2, ax, $urandom_range(0, 31), $urandom);
                1:       set_geometry(e1, e0, e2, ax, $urandom_range(0, 31), $urandom);
                default: set_geometry(e1, e2, e0, ax, $urandom_range(0, 31), $urandom);
            endcase
            send_frame();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sample_extremes();
        test_special_cases();
        test_shrink_mid_frame();
        test_random_frames(0, 0, 60);
        test_random_frames(64, 0, 60);
        test_random_frames(0, 64, 60);
        test_random_frames(10, 10, 60);
        wait_idle();
        $display("Loaded %0d sample pairs and closed %0d frames.", pairs_sent, frames_closed);
        $display("Checked %0d lag results, %0d mismatches.", lag_results, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
